// ===== src/pbs_pkg.sv =====
// shared types, codes and constants for the pump and bypass sequencer
package pbs_pkg;

    localparam int unsigned MS_PER_S   = 1000;
    localparam int unsigned SEC_W      = 16;
    localparam int unsigned MS_W       = 26;
    localparam int unsigned ELAPSED_W  = 27;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned TIMEOUT_RESET_S = 120;

    typedef enum logic [2:0] {
        OP_TICK       = 3'd0,
        OP_START      = 3'd1,
        OP_STOP       = 3'd2,
        OP_DISABLE    = 3'd3,
        OP_BLOWOFF    = 3'd4,
        OP_MIX        = 3'd5,
        OP_BYPASS_OFF = 3'd6
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PUMP_TIMEOUT     = 3'd0,
        CFG_PRIMING          = 3'd1,
        CFG_BLOWOFF          = 3'd2,
        CFG_CLOSING_DELAY    = 3'd3,
        CFG_ENABLED_AT_RESET = 3'd4
    } cfg_index_t;

    typedef enum logic [2:0] {
        CODE_DISABLED = 3'd0,
        CODE_IDLE     = 3'd1,
        CODE_PRIMING  = 3'd2,
        CODE_RUNNING  = 3'd3,
        CODE_BLOWOFF  = 3'd4,
        CODE_CLOSING  = 3'd5,
        CODE_MIXING   = 3'd6
    } state_code_t;

    typedef enum logic [6:0] {
        ST_DISABLED = 7'b0000001,
        ST_IDLE     = 7'b0000010,
        ST_PRIMING  = 7'b0000100,
        ST_RUNNING  = 7'b0001000,
        ST_BLOWOFF  = 7'b0010000,
        ST_CLOSING  = 7'b0100000,
        ST_MIXING   = 7'b1000000
    } mode_t;

    typedef struct packed {
        logic [2:0]       opcode;
        logic             reset_status;
        logic [SEC_W-1:0] mix_seconds;
    } cmd_t;

    typedef struct packed {
        logic [2:0] pump_state;
        logic       pump_on;
        logic       bypass_on;
        logic       pump_enabled;
        logic       timeout_alarm;
    } rsp_t;

    typedef struct packed {
        logic [MS_W-1:0]  timeout_ms;
        logic [MS_W-1:0]  priming_ms;
        logic [MS_W-1:0]  blowoff_ms;
        logic [SEC_W-1:0] closing_ms;
    } limits_t;

    function automatic logic [MS_W-1:0] sec_to_ms(input logic [SEC_W-1:0] secs);
        sec_to_ms = MS_W'(secs) * MS_W'(MS_PER_S);
    endfunction

    function automatic logic [2:0] mode_code(input mode_t m);
        case (m)
            ST_DISABLED: mode_code = CODE_DISABLED;
            ST_IDLE:     mode_code = CODE_IDLE;
            ST_PRIMING:  mode_code = CODE_PRIMING;
            ST_RUNNING:  mode_code = CODE_RUNNING;
            ST_BLOWOFF:  mode_code = CODE_BLOWOFF;
            ST_CLOSING:  mode_code = CODE_CLOSING;
            ST_MIXING:   mode_code = CODE_MIXING;
            default:     mode_code = CODE_DISABLED;
        endcase
    endfunction

endpackage

// ===== src/pump_bypass_sequencer.sv =====
// pump and bypass valve sequencer top level
//
// usage:
//   cmd channel (cmd_valid/cmd_ready/cmd) takes one request per cycle: a
//   one-millisecond tick or a command (start, stop, disable, blow-off, mix,
//   bypass off). each request yields exactly one response on the rsp
//   channel (rsp_valid/rsp_ready/rsp) with state, drives, enable flag and
//   the safety timeout alarm.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the phase
//   times; it is always ready. write it only with no request in flight.
//   response: registered, valid in the cycle after the request is accepted.
//   throughput: one request per cycle unless rsp stalls, set by the single
//   state update between the command port and the response register.
//   reset: state idle, enable flag set, timer and mix limit cleared,
//   safety timeout 120 s, other phase times zero.
//   stall: while the response register is full and rsp_ready is low,
//   cmd_ready is low; a response taken in a cycle frees room for the next
//   request in that same cycle.
module pump_bypass_sequencer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cmd_valid,
    output logic                            cmd_ready,
    input  pbs_pkg::cmd_t                   cmd,
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output pbs_pkg::rsp_t                   rsp,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pbs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pbs_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import pbs_pkg::*;

    limits_t               limits;
    logic                  cmd_fire;

    mode_t                 mode_reg;
    mode_t                 mode_next;
    logic [ELAPSED_W-1:0]  elapsed_reg;
    logic [ELAPSED_W-1:0]  elapsed_next;
    logic [ELAPSED_W-1:0]  elapsed_inc;
    logic [MS_W-1:0]       run_limit_reg;
    logic [MS_W-1:0]       run_limit_next;
    logic                  en_reg;
    logic                  en_next;
    logic                  alarm;
    logic                  go;
    mode_t                 tgt;
    logic                  start_en;

    logic                  rsp_valid_reg;
    logic                  rsp_valid_next;
    rsp_t                  rsp_reg;
    rsp_t                  rsp_next;

    assign cfg_ready = 1'b1;

    pbs_cfg u_cfg (
        .clk    (clk),
        .rst_n  (rst_n),
        .we     (cfg_valid & cfg_ready),
        .index  (cfg_index),
        .data   (cfg_data),
        .limits (limits)
    );

    assign cmd_ready = !rsp_valid_reg || rsp_ready;
    assign cmd_fire  = cmd_valid && cmd_ready;

    assign elapsed_inc = (&elapsed_reg) ? elapsed_reg : elapsed_reg + 1'b1;
    assign start_en    = en_reg | cmd.reset_status;

    always_comb
    begin
        elapsed_next   = elapsed_reg;
        run_limit_next = run_limit_reg;
        en_next        = en_reg;
        alarm          = 1'b0;
        go             = 1'b0;
        tgt            = mode_reg;
        case (cmd.opcode)
            OP_TICK:
            begin
                elapsed_next = elapsed_inc;
                case (mode_reg)
                    ST_PRIMING:
                    begin
                        if (elapsed_inc > ELAPSED_W'(limits.priming_ms))
                        begin
                            go  = 1'b1;
                            tgt = ST_RUNNING;
                        end
                    end
                    ST_RUNNING:
                    begin
                        en_next = 1'b1;
                        if (run_limit_reg != '0 &&
                            elapsed_inc > ELAPSED_W'(run_limit_reg))
                        begin
                            run_limit_next = '0;
                            go  = 1'b1;
                            tgt = (limits.blowoff_ms != '0) ? ST_BLOWOFF : ST_IDLE;
                        end
                        else if (elapsed_inc > ELAPSED_W'(limits.timeout_ms))
                        begin
                            go    = 1'b1;
                            tgt   = ST_DISABLED;
                            alarm = 1'b1;
                        end
                    end
                    ST_BLOWOFF:
                    begin
                        if (elapsed_inc > ELAPSED_W'(limits.blowoff_ms))
                        begin
                            go  = 1'b1;
                            tgt = (limits.closing_ms != '0) ? ST_CLOSING : ST_IDLE;
                        end
                    end
                    ST_CLOSING:
                    begin
                        if (elapsed_inc > ELAPSED_W'(limits.closing_ms))
                        begin
                            go  = 1'b1;
                            tgt = ST_IDLE;
                        end
                    end
                    ST_MIXING:
                    begin
                        en_next = 1'b1;
                        if ((run_limit_reg != '0 &&
                             elapsed_inc > ELAPSED_W'(run_limit_reg)) ||
                            elapsed_inc > ELAPSED_W'(limits.timeout_ms))
                        begin
                            run_limit_next = '0;
                            go  = 1'b1;
                            tgt = (limits.closing_ms != '0) ? ST_CLOSING : ST_IDLE;
                        end
                    end
                    ST_IDLE:
                    begin
                        en_next = 1'b1;
                    end
                    default:
                    begin
                        en_next = 1'b0;
                    end
                endcase
            end
            OP_START:
            begin
                en_next = start_en;
                if (start_en)
                begin
                    go  = 1'b1;
                    tgt = (limits.priming_ms != '0) ? ST_PRIMING : ST_RUNNING;
                end
            end
            OP_STOP:
            begin
                go  = 1'b1;
                tgt = (limits.blowoff_ms != '0) ? ST_BLOWOFF : ST_IDLE;
            end
            OP_DISABLE:
            begin
                go  = 1'b1;
                tgt = ST_DISABLED;
            end
            OP_BLOWOFF:
            begin
                go  = 1'b1;
                tgt = ST_BLOWOFF;
            end
            OP_MIX:
            begin
                run_limit_next = sec_to_ms(cmd.mix_seconds);
                go  = 1'b1;
                tgt = ST_MIXING;
            end
            OP_BYPASS_OFF:
            begin
                go  = 1'b1;
                tgt = en_reg ? ST_IDLE : ST_DISABLED;
            end
            default: ;
        endcase

        mode_next = mode_reg;
        if (go)
        begin
            mode_next    = tgt;
            elapsed_next = '0;
            if (tgt inside {ST_IDLE, ST_RUNNING, ST_MIXING})
            begin
                en_next = 1'b1;
            end
            else if (tgt == ST_DISABLED)
            begin
                en_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        rsp_next.pump_state    = mode_code(mode_next);
        rsp_next.pump_on       = (mode_next inside {ST_PRIMING, ST_RUNNING, ST_MIXING});
        rsp_next.bypass_on     = (mode_next inside {ST_PRIMING, ST_BLOWOFF, ST_MIXING});
        rsp_next.pump_enabled  = en_next;
        rsp_next.timeout_alarm = alarm;
        rsp_valid_next = cmd_fire | (rsp_valid_reg & !rsp_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= ST_IDLE;
            elapsed_reg   <= '0;
            run_limit_reg <= '0;
            en_reg        <= 1'b1;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (cmd_fire)
            begin
                mode_reg      <= mode_next;
                elapsed_reg   <= elapsed_next;
                run_limit_reg <= run_limit_next;
                en_reg        <= en_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_mode_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(mode_reg))
        else $error("state register lost its one-hot code");

    a_enabled_states: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == ST_IDLE || mode_reg == ST_RUNNING || mode_reg == ST_MIXING)
        |-> en_reg)
        else $error("active state with enable flag clear");

    a_disabled_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == ST_DISABLED) |-> !en_reg)
        else $error("disabled state with enable flag set");

    a_alarm_disables: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.timeout_alarm)
        |-> (rsp_reg.pump_state == CODE_DISABLED && !rsp_reg.pump_enabled))
        else $error("timeout alarm without entering disabled");

    a_request_response: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_fire |=> rsp_valid_reg)
        else $error("accepted request produced no response");

endmodule

// ===== src/pbs_cfg.sv =====
// configuration registers, phase limits kept in milliseconds
module pbs_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            we,
    input  logic [pbs_pkg::CFG_IDX_W-1:0]   index,
    input  logic [pbs_pkg::CFG_DATA_W-1:0]  data,
    output pbs_pkg::limits_t                limits
);
    import pbs_pkg::*;

    limits_t limits_reg;
    limits_t limits_next;

    always_comb
    begin
        limits_next = limits_reg;
        if (we)
        begin
            case (index)
                CFG_PUMP_TIMEOUT:  limits_next.timeout_ms = sec_to_ms(data);
                CFG_PRIMING:       limits_next.priming_ms = sec_to_ms(data);
                CFG_BLOWOFF:       limits_next.blowoff_ms = sec_to_ms(data);
                CFG_CLOSING_DELAY: limits_next.closing_ms = data;
                // the written value is not stored; reset always restores the enable flag
                CFG_ENABLED_AT_RESET: ;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.timeout_ms <= sec_to_ms(SEC_W'(TIMEOUT_RESET_S));
            limits_reg.priming_ms <= '0;
            limits_reg.blowoff_ms <= '0;
            limits_reg.closing_ms <= '0;
        end
        else
        begin
            limits_reg <= limits_next;
        end
    end

    assign limits = limits_reg;

endmodule

// ===== test/testbench.sv =====
// self-checking testbench for the pump and bypass valve sequencer
module testbench;
    import pbs_pkg::*;

    localparam logic [2:0] OP_UNUSED = 3'd7;
    localparam logic [2:0] CFG_SPARE_LO = 3'd5;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;
    localparam logic [ELAPSED_W-1:0] ELAPSED_TOP = '1;
    localparam int IDLE_PERCENT = 24;
    localparam int HOLD_CYCLES = 60;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_ITEMS = 380;
    localparam int SEQUENCES_PER_PHASE = 10;

    logic clk = 1'b0;
    logic rst_n;
    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // sequencer state as predicted
    state_code_t pump_mode;
    logic [ELAPSED_W-1:0] held_ms;
    logic [SEC_W-1:0] mix_limit_s;
    logic enable_flag;
    logic [SEC_W-1:0] timeout_s;
    logic [SEC_W-1:0] priming_s;
    logic [SEC_W-1:0] blowoff_s;
    logic [SEC_W-1:0] closing_ms;

    rsp_t status_due[$];
    rsp_t status_want;
    int mismatch_count = 0;
    int response_count = 0;
    int sent_total = 0;
    int cfg_total = 0;
    int alarm_total = 0;
    int phase_total = 0;
    logic [6:0] states_seen = '0;
    bit steady = 1'b0;
    bit hold_req = 1'b0;
    int hold_left = 0;
    int quiet_cycles = 0;

    pump_bypass_sequencer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic bit past_secs(input logic [SEC_W-1:0] secs);
        return longint'(held_ms) > longint'(secs) * longint'(MS_PER_S);
    endfunction

    function automatic void enter_mode(input state_code_t next);
        pump_mode = next;
        held_ms = '0;
        if (next == CODE_IDLE || next == CODE_RUNNING || next == CODE_MIXING)
            enable_flag = 1'b1;
        else if (next == CODE_DISABLED)
            enable_flag = 1'b0;
    endfunction

    function automatic rsp_t next_status(input cmd_t item);
        rsp_t result;
        logic alarm;
        alarm = 1'b0;
        case (item.opcode)
            OP_TICK:
            begin
                if (held_ms != ELAPSED_TOP)
                    held_ms = held_ms + 1'b1;
                case (pump_mode)
                    CODE_PRIMING:
                    begin
                        if (past_secs(priming_s))
                            enter_mode(CODE_RUNNING);
                    end
                    CODE_RUNNING:
                    begin
                        enable_flag = 1'b1;
                        if (mix_limit_s != 0 && past_secs(mix_limit_s))
                        begin
                            mix_limit_s = '0;
                            enter_mode(blowoff_s != 0 ? CODE_BLOWOFF : CODE_IDLE);
                        end
                        else if (past_secs(timeout_s))
                        begin
                            enter_mode(CODE_DISABLED);
                            alarm = 1'b1;
                        end
                    end
                    CODE_BLOWOFF:
                    begin
                        if (past_secs(blowoff_s))
                            enter_mode(closing_ms != 0 ? CODE_CLOSING : CODE_IDLE);
                    end
                    CODE_CLOSING:
                    begin
                        if (held_ms > ELAPSED_W'(closing_ms))
                            enter_mode(CODE_IDLE);
                    end
                    CODE_MIXING:
                    begin
                        enable_flag = 1'b1;
                        if ((mix_limit_s != 0 && past_secs(mix_limit_s)) || past_secs(timeout_s))
                        begin
                            mix_limit_s = '0;
                            enter_mode(closing_ms != 0 ? CODE_CLOSING : CODE_IDLE);
                        end
                    end
                    CODE_IDLE:
                        enable_flag = 1'b1;
                    default:
                        enable_flag = 1'b0;
                endcase
            end
            OP_START:
            begin
                if (item.reset_status)
                    enable_flag = 1'b1;
                if (enable_flag)
                    enter_mode(priming_s != 0 ? CODE_PRIMING : CODE_RUNNING);
            end
            OP_STOP:
                enter_mode(blowoff_s != 0 ? CODE_BLOWOFF : CODE_IDLE);
            OP_DISABLE:
                enter_mode(CODE_DISABLED);
            OP_BLOWOFF:
                enter_mode(CODE_BLOWOFF);
            OP_MIX:
            begin
                mix_limit_s = item.mix_seconds;
                enter_mode(CODE_MIXING);
            end
            OP_BYPASS_OFF:
                enter_mode(enable_flag ? CODE_IDLE : CODE_DISABLED);
            default:
            begin
            end
        endcase
        result.pump_state = pump_mode;
        result.pump_on = (pump_mode == CODE_PRIMING || pump_mode == CODE_RUNNING
                          || pump_mode == CODE_MIXING);
        result.bypass_on = (pump_mode == CODE_PRIMING || pump_mode == CODE_BLOWOFF
                            || pump_mode == CODE_MIXING);
        result.pump_enabled = enable_flag;
        result.timeout_alarm = alarm;
        states_seen[pump_mode] = 1'b1;
        if (alarm)
            alarm_total++;
        return result;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("mismatch on %s: got %0h, expected %0h (response %0d)",
                 what, got, want, response_count);
        mismatch_count++;
    endtask

    task automatic send_op(input logic [2:0] op, input logic flag, input logic [SEC_W-1:0] mix);
        cmd_t item;
        item.opcode = op;
        item.reset_status = flag;
        item.mix_seconds = mix;
        if (!steady && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= item;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        status_due.push_back(next_status(item));
        sent_total++;
    endtask

    task automatic send_ticks(input int count);
        repeat (count)
            send_op(OP_TICK, 1'($urandom), 16'($urandom));
    endtask

    task automatic drain_all();
        cmd_valid <= 1'b0;
        while (status_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_PUMP_TIMEOUT:     timeout_s = value;
            CFG_PRIMING:          priming_s = value;
            CFG_BLOWOFF:          blowoff_s = value;
            CFG_CLOSING_DELAY:    closing_ms = value;
            // the written value is not kept; reset always restores the enable flag
            CFG_ENABLED_AT_RESET:
            begin
            end
            default:
            begin
            end
        endcase
        cfg_total++;
    endtask

    // every register plus one spare index, written only with nothing in flight
    task automatic set_timers(input logic [SEC_W-1:0] timeout, input logic [SEC_W-1:0] priming,
                              input logic [SEC_W-1:0] blowoff, input logic [SEC_W-1:0] closing,
                              input logic [CFG_DATA_W-1:0] reset_word);
        drain_all();
        write_reg(CFG_PUMP_TIMEOUT, timeout);
        write_reg(CFG_PRIMING, priming);
        write_reg(CFG_BLOWOFF, blowoff);
        write_reg(CFG_CLOSING_DELAY, closing);
        write_reg(CFG_ENABLED_AT_RESET, reset_word);
        write_reg(3'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)), 16'($urandom));
        cfg_valid <= 1'b0;
        phase_total++;
    endtask

    task automatic test_reset_state();
        send_op(OP_TICK, 1'b0, 16'h0000);
        send_op(OP_UNUSED, 1'b1, 16'hFFFF);
    endtask

    task automatic test_zero_timeout();
        set_timers(16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF);
        send_op(OP_START, 1'b0, 16'h0000);
        send_op(OP_TICK, 1'b0, 16'h0000);
        // disabled: start without reset_status is ignored
        send_op(OP_START, 1'b0, 16'h0000);
        send_op(OP_TICK, 1'b1, 16'h0000);
        send_op(OP_START, 1'b1, 16'h0000);
        send_op(OP_BYPASS_OFF, 1'b0, 16'h0000);
        send_op(OP_DISABLE, 1'b0, 16'h0000);
        send_op(OP_BYPASS_OFF, 1'b1, 16'h0000);
    endtask

    task automatic test_closing_path();
        set_timers(16'd0, 16'd0, 16'd0, 16'd2, 16'h0001);
        send_op(OP_MIX, 1'b0, 16'h0000);
        send_ticks(4);
        // blow-off with zero time still enters the state for one tick
        send_op(OP_BLOWOFF, 1'b0, 16'h0000);
        send_op(OP_TICK, 1'b0, 16'h0000);
        send_op(OP_STOP, 1'b0, 16'h0000);
    endtask

    task automatic test_extremes();
        set_timers(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
        send_op(OP_START, 1'b0, 16'h0000);
        send_op(OP_TICK, 1'b0, 16'h0000);
        send_op(OP_STOP, 1'b1, 16'hFFFF);
        send_op(OP_BYPASS_OFF, 1'b0, 16'h0000);
        send_op(OP_MIX, 1'b0, 16'hFFFF);
        send_op(OP_TICK, 1'b0, 16'h0000);
        send_op(OP_BLOWOFF, 1'b1, 16'hFFFF);
        send_op(OP_TICK, 1'b0, 16'h0000);
    endtask

    // leftover mix limit in a run, expiring on the same tick as the one-second safety timeout
    task automatic test_second_timers();
        set_timers(16'd1, 16'd0, 16'd0, 16'd3, 16'h0001);
        send_op(OP_MIX, 1'b0, 16'd1);
        send_op(OP_START, 1'b0, 16'h0000);
        send_ticks(1001);
        send_ticks(4);
    endtask

    task automatic test_backpressure();
        steady = 1'b1;
        hold_req = 1'b1;
        send_op(OP_MIX, 1'b1, 16'h0000);
        send_ticks(30);
        steady = 1'b0;
    endtask

    function automatic logic [SEC_W-1:0] pick_seconds();
        case ($urandom_range(0, 9))
            0, 1, 2:    pick_seconds = 16'd0;
            3, 4, 5, 6: pick_seconds = 16'd1;
            7, 8:       pick_seconds = 16'd2;
            default:    pick_seconds = 16'($urandom);
        endcase
    endfunction

    task automatic random_sequence();
        logic [2:0] op;
        logic [SEC_W-1:0] mix;
        int burst;
        mix = ($urandom_range(0, 9) < 5) ? 16'($urandom_range(0, 2)) : 16'($urandom);
        if ($urandom_range(0, 9) < 8)
        begin
            case ($urandom_range(0, 7))
                0, 1, 2: op = OP_START;
                3:       op = OP_MIX;
                4:       op = OP_STOP;
                5:       op = OP_BLOWOFF;
                6:       op = OP_BYPASS_OFF;
                default: op = OP_DISABLE;
            endcase
            send_op(op, 1'($urandom), mix);
            if ($urandom_range(0, 7) == 0)
                burst = $urandom_range(30, 60);
            else
                burst = $urandom_range(0, 25);
            send_ticks(burst);
        end
        else
            send_op(3'($urandom), 1'($urandom), mix);
    endtask

    task automatic test_random();
        int first;
        int phase;
        logic [SEC_W-1:0] closing;
        first = sent_total;
        phase = 0;
        while (sent_total - first < RANDOM_ITEMS)
        begin
            closing = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
            set_timers(pick_seconds(), pick_seconds(), pick_seconds(), closing, 16'($urandom));
            steady = (phase == 2);
            repeat (SEQUENCES_PER_PHASE)
                random_sequence();
            phase++;
        end
        steady = 1'b0;
    endtask

    // response side: random stalls, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left != 0)
            begin
                rsp_ready <= 1'b0;
                hold_left--;
            end
            else if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            response_count++;
            if (status_due.size() == 0)
                report_mismatch("response with nothing pending", 8'(rsp), 8'h00);
            else
            begin
                status_want = status_due.pop_front();
                if (rsp.pump_state !== status_want.pump_state)
                    report_mismatch("pump_state", 8'(rsp.pump_state), 8'(status_want.pump_state));
                if (rsp.pump_on !== status_want.pump_on)
                    report_mismatch("pump_on", 8'(rsp.pump_on), 8'(status_want.pump_on));
                if (rsp.bypass_on !== status_want.bypass_on)
                    report_mismatch("bypass_on", 8'(rsp.bypass_on), 8'(status_want.bypass_on));
                if (rsp.pump_enabled !== status_want.pump_enabled)
                    report_mismatch("pump_enabled", 8'(rsp.pump_enabled),
                                    8'(status_want.pump_enabled));
                if (rsp.timeout_alarm !== status_want.timeout_alarm)
                    report_mismatch("timeout_alarm", 8'(rsp.timeout_alarm),
                                    8'(status_want.timeout_alarm));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        cmd_valid <= 1'b0;
        cmd <= '0;
        rsp_ready <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        timeout_s = 16'(TIMEOUT_RESET_S);
        priming_s = '0;
        blowoff_s = '0;
        closing_ms = '0;
        pump_mode = CODE_IDLE;
        held_ms = '0;
        mix_limit_s = '0;
        enable_flag = 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_zero_timeout();
        test_closing_path();
        test_extremes();
        test_second_timers();
        test_backpressure();
        test_random();

        drain_all();
        repeat (4) @(posedge clk);
        if (status_due.size() != 0)
            report_mismatch("responses still pending", 8'(status_due.size()), 8'h00);
        $display("run covered %0d requests, %0d register writes over %0d settings",
                 sent_total, cfg_total, phase_total);
        $display("states reached %b, safety alarms predicted %0d", states_seen, alarm_total);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
